[rtl/dq_pkg.sv]
// shared types and constants for the double-ended queue
package dq_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_dq_mode;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } t_dq_state;

    typedef struct packed {
        logic exec;
        logic load;
    } t_dq_cmd;

    typedef struct packed {
        logic out_free;
    } t_dq_sts;

endpackage

[rtl/dq_ram.sv]
// generic single-write single-read ram with registered read
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/dq_ctrl.sv]
// controller state machine for the double-ended queue
module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  dq_pkg::t_dq_sts i_sts,
    output dq_pkg::t_dq_cmd o_cmd
);

    import dq_pkg::*;

    t_dq_state r_state;
    t_dq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.exec = i_s_tvalid;
            end
            ST_FINISH: begin
                o_cmd.load = i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    a_exec_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_state == ST_FINISH)
        else $error("exec did not lead to finish");

    a_no_exec_and_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.exec && o_cmd.load))
        else $error("exec and load in one cycle");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_s_tready)
        else $error("load did not return to idle");

endmodule

[rtl/dq_datapath.sv]
// index, count, cached end values, ring memory and result register
module dq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dq_pkg::t_dq_cmd               i_cmd,
    output dq_pkg::t_dq_sts               o_sts,
    input  dq_pkg::t_dq_mode              i_mode,
    input  logic signed [31:0]            i_push_value,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic signed [31:0]            o_front_value,
    output logic signed [31:0]            o_back_value,
    output logic [4:0]                    o_entry_count,
    output logic                          o_underflow,
    output logic                          o_overflow
);

    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
        logic [AW-1:0] y;
        y = (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
        return y;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
        logic [AW-1:0] y;
        y = (x == '0) ? AW'(DEPTH - 1) : x - AW'(1);
        return y;
    endfunction

    logic [AW-1:0]        r_front_idx;
    logic [AW-1:0]        r_back_idx;
    logic [CW-1:0]        r_count;
    logic [VALUE_W-1:0]   r_front_val;
    logic [VALUE_W-1:0]   r_back_val;
    logic                 r_rd_pend;
    logic                 r_rd_front;
    logic                 r_under;
    logic                 r_over;

    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_front;
    logic [VALUE_W-1:0]   r_out_back;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                 r_out_under;
    logic                 r_out_over;

    logic                 w_push;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic [VALUE_W-1:0]   w_rd_data;
    logic [VALUE_W-1:0]   w_front_res;
    logic [VALUE_W-1:0]   w_back_res;
    logic [CW+COUNT_OUT_W-1:0] w_count_ext;

    assign w_push  = (i_mode == MODE_PUSH_BACK) || (i_mode == MODE_PUSH_FRONT);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_wr_addr = r_front_idx;
        if (!w_empty) begin
            w_wr_addr = (i_mode == MODE_PUSH_BACK) ? idx_inc(r_back_idx) : idx_dec(r_front_idx);
        end
    end

    assign w_wr_en   = i_cmd.exec && w_push && !w_full;
    assign w_rd_en   = i_cmd.exec && !w_push && (r_count > CW'(1));
    assign w_rd_addr = (i_mode == MODE_POP_FRONT) ? idx_inc(r_front_idx) : idx_dec(r_back_idx);

    dq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // operation step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_idx <= '0;
            r_back_idx  <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_front  <= 1'b0;
            r_under     <= 1'b0;
            r_over      <= 1'b0;
        end else if (i_cmd.exec) begin
            r_under    <= !w_push && w_empty;
            r_over     <= w_push && w_full;
            r_rd_pend  <= w_rd_en;
            r_rd_front <= (i_mode == MODE_POP_FRONT);
            if (w_push && !w_full) begin
                r_count <= r_count + CW'(1);
                if (!w_empty) begin
                    if (i_mode == MODE_PUSH_BACK) begin
                        r_back_idx <= w_wr_addr;
                    end else begin
                        r_front_idx <= w_wr_addr;
                    end
                end
            end else if (!w_push && !w_empty) begin
                r_count <= r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    r_front_idx <= '0;
                    r_back_idx  <= '0;
                end else if (i_mode == MODE_POP_FRONT) begin
                    r_front_idx <= w_rd_addr;
                end else begin
                    r_back_idx <= w_rd_addr;
                end
            end
        end
    end

    // cached end values
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_push && !w_full) begin
            if (w_empty) begin
                r_front_val <= i_push_value;
                r_back_val  <= i_push_value;
            end else if (i_mode == MODE_PUSH_BACK) begin
                r_back_val <= i_push_value;
            end else begin
                r_front_val <= i_push_value;
            end
        end else if (i_cmd.load) begin
            r_front_val <= w_front_res;
            r_back_val  <= w_back_res;
        end
    end

    always_comb begin
        w_front_res = (r_rd_pend && r_rd_front) ? w_rd_data : r_front_val;
        w_back_res  = (r_rd_pend && !r_rd_front) ? w_rd_data : r_back_val;
        if (r_count == '0) begin
            w_front_res = '0;
            w_back_res  = '0;
        end
    end

    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, r_count};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_front <= w_front_res;
            r_out_back  <= w_back_res;
            r_out_count <= w_count_ext[COUNT_OUT_W-1:0];
            r_out_under <= r_under;
            r_out_over  <= r_over;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_entry_count  = r_out_count;
    assign o_underflow    = r_out_under;
    assign o_overflow     = r_out_over;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_under && r_out_over))
        else $error("underflow and overflow together");

    a_underflow_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !w_push && w_empty) |=> r_under && r_count == '0)
        else $error("pop on empty not flagged");

    a_overflow_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_push && w_full) |=> r_over && r_count == CW'(DEPTH))
        else $error("push on full changed state");

endmodule

[rtl/double_ended_queue_unit.sv]
// top level of the bounded double-ended queue
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  mode, push_value
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  front, back, count, underflow, overflow
//
//  per transaction, the operation step updates indices and count and
//  writes or reads the ring memory, then the result is loaded into the output register
//  a separate result step is needed for the registered read of the ring memory on pops
//  reset clears indices, count and valid state; memory contents need no clearing
//  a new transaction is taken while a finished result still waits in the output register
//  the result step stalls while the output register is full and not taken
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] mode, [33:2] push_value, [39:34] zero
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] front_value, [63:32] back_value, [68:64] entry_count,
    // [69] underflow, [70] overflow, [71] zero
    output logic [71:0] o_m_axis_tdata
);

    import dq_pkg::*;

    t_dq_cmd            w_cmd;
    t_dq_sts            w_sts;
    t_dq_mode           w_mode;
    logic signed [31:0] w_push_value;
    logic signed [31:0] w_front_value;
    logic signed [31:0] w_back_value;
    logic [4:0]         w_entry_count;
    logic               w_underflow;
    logic               w_overflow;

    assign w_mode       = t_dq_mode'(i_s_axis_tdata[1:0]);
    assign w_push_value = i_s_axis_tdata[33:2];

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_mode        (w_mode),
        .i_push_value  (w_push_value),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tvalid    (o_m_axis_tvalid),
        .o_front_value (w_front_value),
        .o_back_value  (w_back_value),
        .o_entry_count (w_entry_count),
        .o_underflow   (w_underflow),
        .o_overflow    (w_overflow)
    );

    assign o_m_axis_tdata = {1'b0, w_overflow, w_underflow, w_entry_count,
                             w_back_value, w_front_value};

endmodule
